// ----- hw/rtl/vds_pkg.sv -----
package vds_pkg;

    // Field widths
    localparam int TAG_W   = 16;
    localparam int CEN_W   = 32;
    localparam int DIR_W   = 16;
    localparam int PROD_W  = 48;
    localparam int DEPTH_W = 50;

    // Configuration port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_DIR_X = 2'd0;
    localparam logic [1:0] REG_DIR_Y = 2'd1;
    localparam logic [1:0] REG_DIR_Z = 2'd2;

    localparam logic [DIR_W-1:0] DIR_X_RESET = 16'h0000;
    localparam logic [DIR_W-1:0] DIR_Y_RESET = 16'h0000;
    localparam logic [DIR_W-1:0] DIR_Z_RESET = 16'h4000;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_START,
        ST_SCAN,
        ST_EMIT,
        ST_NONE
    } sort_state_t;

    // Depth unit to sequencer: one loaded word
    typedef struct packed {
        logic                      valid;
        logic [TAG_W-1:0]          tag;
        logic signed [DEPTH_W-1:0] depth;
        logic                      geo;
        logic                      last;
    } load_word_t;

endpackage

// ----- hw/rtl/vds_in_if.sv -----
interface vds_in_if;
    import vds_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [TAG_W-1:0]        item_tag;
    logic signed [CEN_W-1:0] center_x;
    logic signed [CEN_W-1:0] center_y;
    logic signed [CEN_W-1:0] center_z;
    logic                    has_geometry;
    logic                    last_in;

    modport source (
        output valid, item_tag, center_x, center_y, center_z, has_geometry, last_in,
        input  ready
    );

    modport sink (
        input  valid, item_tag, center_x, center_y, center_z, has_geometry, last_in,
        output ready
    );

endinterface

// ----- hw/rtl/vds_out_if.sv -----
interface vds_out_if;
    import vds_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [TAG_W-1:0]          out_tag;
    logic signed [DEPTH_W-1:0] out_depth;
    logic                      last_out;
    logic                      none_rendered;
    logic                      overflowed;

    modport source (
        output valid, out_tag, out_depth, last_out, none_rendered, overflowed,
        input  ready
    );

    modport sink (
        input  valid, out_tag, out_depth, last_out, none_rendered, overflowed,
        output ready
    );

endinterface

// ----- hw/rtl/vds_ram.sv -----
module vds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/vds_depth_unit.sv -----
module vds_depth_unit import vds_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    vds_in_if.sink                  items,
    input  logic                    load_open,
    input  logic signed [DIR_W-1:0] dir_x,
    input  logic signed [DIR_W-1:0] dir_y,
    input  logic signed [DIR_W-1:0] dir_z,
    output load_word_t              ld
);

    logic                     accept;
    logic                     vld_reg;
    logic signed [PROD_W-1:0] prod_x_next;
    logic signed [PROD_W-1:0] prod_y_next;
    logic signed [PROD_W-1:0] prod_z_next;
    logic signed [PROD_W-1:0] prod_x_reg;
    logic signed [PROD_W-1:0] prod_y_reg;
    logic signed [PROD_W-1:0] prod_z_reg;
    logic [TAG_W-1:0]         tag_reg;
    logic                     geo_reg;
    logic                     last_reg;

    // Take a word only while loading and the product stage is empty
    assign items.ready = load_open && !vld_reg;
    assign accept      = items.valid && items.ready;

    // One 32x16 multiplier per axis
    assign prod_x_next = $signed({{(PROD_W-CEN_W){items.center_x[CEN_W-1]}}, items.center_x})
                       * $signed({{(PROD_W-DIR_W){dir_x[DIR_W-1]}}, dir_x});
    assign prod_y_next = $signed({{(PROD_W-CEN_W){items.center_y[CEN_W-1]}}, items.center_y})
                       * $signed({{(PROD_W-DIR_W){dir_y[DIR_W-1]}}, dir_y});
    assign prod_z_next = $signed({{(PROD_W-CEN_W){items.center_z[CEN_W-1]}}, items.center_z})
                       * $signed({{(PROD_W-DIR_W){dir_z[DIR_W-1]}}, dir_z});

    // Product stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= accept;
        end
    end

    // Product stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            prod_z_reg <= prod_z_next;
            tag_reg    <= items.item_tag;
            geo_reg    <= items.has_geometry;
            last_reg   <= items.last_in;
        end
    end

    // Sum the three products, exact in Q20.30
    always_comb
    begin
        ld.valid = vld_reg;
        ld.tag   = tag_reg;
        ld.geo   = geo_reg;
        ld.last  = last_reg;
        ld.depth = $signed({{(DEPTH_W-PROD_W){prod_x_reg[PROD_W-1]}}, prod_x_reg})
                 + $signed({{(DEPTH_W-PROD_W){prod_y_reg[PROD_W-1]}}, prod_y_reg})
                 + $signed({{(DEPTH_W-PROD_W){prod_z_reg[PROD_W-1]}}, prod_z_reg});
    end

endmodule

// ----- hw/rtl/vds_sort_ctrl.sv -----
module vds_sort_ctrl import vds_pkg::*; #(
    parameter int MAX_ITEMS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  load_word_t ld,
    output logic       load_open,
    vds_out_if.source  results
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    sort_state_t state_reg;
    sort_state_t state_next;

    logic [CW-1:0]             count_reg;
    logic                      ovf_reg;
    logic [CW-1:0]             scan_cnt_reg;
    logic [CW-1:0]             emit_cnt_reg;
    logic                      rd_pend_reg;
    logic [AW-1:0]             rd_idx_reg;
    logic signed [DEPTH_W-1:0] prev_depth_reg;
    logic [AW-1:0]             prev_idx_reg;
    logic                      found_reg;
    logic signed [DEPTH_W-1:0] best_depth_reg;
    logic [TAG_W-1:0]          best_tag_reg;
    logic [AW-1:0]             best_idx_reg;

    logic                      out_vld_reg;
    logic [TAG_W-1:0]          out_tag_reg;
    logic signed [DEPTH_W-1:0] out_depth_reg;
    logic                      out_last_reg;
    logic                      out_none_reg;
    logic                      out_ovf_reg;

    logic                      store_we;
    logic                      has_room;
    logic                      issue;
    logic                      out_free;
    logic                      out_load;
    logic                      emit_last;
    logic                      after_prev;
    logic                      take;
    logic [AW-1:0]             raddr;
    logic signed [DEPTH_W-1:0] rd_depth;
    logic [TAG_W-1:0]          rd_tag;

    // Depth and tag stores share addresses
    vds_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (MAX_ITEMS)
    ) u_depth_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (ld.depth),
        .raddr (raddr),
        .rdata (rd_depth)
    );

    vds_ram #(
        .WIDTH (TAG_W),
        .DEPTH (MAX_ITEMS)
    ) u_tag_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (ld.tag),
        .raddr (raddr),
        .rdata (rd_tag)
    );

    assign has_room  = count_reg < CW'(MAX_ITEMS);
    assign emit_last = (emit_cnt_reg + CW'(1)) == count_reg;
    assign out_free  = !out_vld_reg || results.ready;

    // A word is a candidate only if it follows the last emitted one in output order
    assign after_prev = (emit_cnt_reg == '0)
                      || (rd_depth < prev_depth_reg)
                      || ((rd_depth == prev_depth_reg) && (rd_idx_reg < prev_idx_reg));
    assign take       = rd_pend_reg && after_prev
                      && (!found_reg || (rd_depth >= best_depth_reg));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (ld.valid && ld.last)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = (count_reg == '0) ? ST_NONE : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (!issue && !rd_pend_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = emit_last ? ST_LOAD : ST_SCAN;
                end
            end
            ST_NONE:
            begin
                if (out_free)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        load_open = 1'b0;
        store_we  = 1'b0;
        issue     = 1'b0;
        out_load  = 1'b0;
        raddr     = scan_cnt_reg[AW-1:0];
        case (state_reg)
            ST_LOAD:
            begin
                load_open = 1'b1;
                store_we  = ld.valid && ld.geo && has_room;
            end
            ST_SCAN:
            begin
                issue = scan_cnt_reg != count_reg;
            end
            ST_EMIT,
            ST_NONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                load_open = 1'b0;
            end
        endcase
    end

    // State and frame bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            scan_cnt_reg <= '0;
            emit_cnt_reg <= '0;
            rd_pend_reg  <= 1'b0;
            found_reg    <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= issue;

            // Count stored words, flag drops once full
            if (store_we)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (state_reg == ST_LOAD && ld.valid && ld.geo && !has_room)
            begin
                ovf_reg <= 1'b1;
            end

            // Open a new sort
            if (state_reg == ST_START)
            begin
                scan_cnt_reg <= '0;
                emit_cnt_reg <= '0;
                found_reg    <= 1'b0;
            end

            // Advance the scan, track the running maximum
            if (issue)
            begin
                scan_cnt_reg <= scan_cnt_reg + CW'(1);
            end
            if (take)
            begin
                found_reg <= 1'b1;
            end

            // Hand the selected word to the output register
            if (state_reg == ST_EMIT && out_load)
            begin
                emit_cnt_reg <= emit_cnt_reg + CW'(1);
                scan_cnt_reg <= '0;
                found_reg    <= 1'b0;
                if (emit_last)
                begin
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                end
            end
            if (state_reg == ST_NONE && out_load)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end

            // Output valid
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Scan and output payload
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_idx_reg <= scan_cnt_reg[AW-1:0];
        end
        if (take)
        begin
            best_depth_reg <= rd_depth;
            best_tag_reg   <= rd_tag;
            best_idx_reg   <= rd_idx_reg;
        end
        // Remember the emitted word as the bound for the next pass
        if (state_reg == ST_EMIT && out_load)
        begin
            prev_depth_reg <= best_depth_reg;
            prev_idx_reg   <= best_idx_reg;
        end
        if (out_load)
        begin
            if (state_reg == ST_NONE)
            begin
                out_tag_reg   <= '0;
                out_depth_reg <= '0;
                out_last_reg  <= 1'b1;
                out_none_reg  <= 1'b1;
            end
            else
            begin
                out_tag_reg   <= best_tag_reg;
                out_depth_reg <= best_depth_reg;
                out_last_reg  <= emit_last;
                out_none_reg  <= 1'b0;
            end
            out_ovf_reg <= ovf_reg;
        end
    end

    assign results.valid         = out_vld_reg;
    assign results.out_tag       = out_tag_reg;
    assign results.out_depth     = out_depth_reg;
    assign results.last_out      = out_last_reg;
    assign results.none_rendered = out_none_reg;
    assign results.overflowed    = out_ovf_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ITEMS))
        else $error("item count beyond capacity");

    a_emit_found: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> found_reg)
        else $error("emit without a selected word");

    a_ovf_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovf_reg) |-> $past(count_reg) == CW'(MAX_ITEMS))
        else $error("overflow flagged with room left");

    a_scan_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> emit_cnt_reg < count_reg)
        else $error("scan started with every word emitted");
`endif

endmodule

// ----- hw/rtl/view_depth_sort.sv -----
// Back-to-front ordering of geometry items by view depth.
// Input channel (items): one word per item, accepted on valid && ready. A word
// with has_geometry stores its tag and depth (centre dot view direction, Q20.30);
// others are dropped. Beyond MAX_ITEMS stored words, further ones are dropped and
// the overflow flag is raised. The word with last_in closes the frame.
// Load: a word is taken only once the one before it has left the product stage
// (multiply stage, then sum and store write). After the closing word the
// sequencer scans the stores once per result; each pass reads every stored word.
// Output channel (results): deepest first, later-loaded first on equal depth,
// last_out on the final word; an empty frame gives one word with none_rendered.
// A result sits in an output register; when the receiver stalls, the sequencer
// holds the next selected word and waits. Loading of the next frame opens as
// soon as the final result of a frame enters the output register.
// Configuration: APB, view_dir_x/y/z at byte addresses 0, 4, 8; to be written
// only while idle by the user; the block itself does not enforce this. Reset
// clears counts and flags and loads the view direction to +z.
module view_depth_sort import vds_pkg::*; #(
    parameter int MAX_ITEMS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    vds_in_if.sink            items,
    vds_out_if.source         results,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [DIR_W-1:0] dir_x_reg;
    logic [DIR_W-1:0] dir_y_reg;
    logic [DIR_W-1:0] dir_z_reg;
    logic             cfg_write;
    logic             load_open;
    load_word_t       ld;

    // Register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_x_reg <= DIR_X_RESET;
            dir_y_reg <= DIR_Y_RESET;
            dir_z_reg <= DIR_Z_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_DIR_X: dir_x_reg <= pwdata[DIR_W-1:0];
                REG_DIR_Y: dir_y_reg <= pwdata[DIR_W-1:0];
                REG_DIR_Z: dir_z_reg <= pwdata[DIR_W-1:0];
                default:   dir_x_reg <= dir_x_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_DIR_X: prdata = {{(APB_DW-DIR_W){1'b0}}, dir_x_reg};
            REG_DIR_Y: prdata = {{(APB_DW-DIR_W){1'b0}}, dir_y_reg};
            REG_DIR_Z: prdata = {{(APB_DW-DIR_W){1'b0}}, dir_z_reg};
            default:   prdata = '0;
        endcase
    end

    // Depth pipeline
    vds_depth_unit u_depth (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .load_open (load_open),
        .dir_x     ($signed(dir_x_reg)),
        .dir_y     ($signed(dir_y_reg)),
        .dir_z     ($signed(dir_z_reg)),
        .ld        (ld)
    );

    // Stores and selection sequencer
    vds_sort_ctrl #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_sort (
        .clk       (clk),
        .rst_n     (rst_n),
        .ld        (ld),
        .load_open (load_open),
        .results   (results)
    );

endmodule

// ----- dv/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import vds_pkg::*;

    localparam int MAX_ITEMS      = 64;
    localparam int HOLD_CYCLES    = 400;
    localparam int ITEMS_PER_PASS = 80;

    typedef struct {
        logic [TAG_W-1:0]        tag;
        logic signed [CEN_W-1:0] cx;
        logic signed [CEN_W-1:0] cy;
        logic signed [CEN_W-1:0] cz;
        logic                    geo;
        logic                    is_last;
    } scene_item_t;

    typedef struct {
        logic [TAG_W-1:0]          tag;
        logic signed [DEPTH_W-1:0] depth;
        logic                      is_last;
        logic                      none;
        logic                      ovf;
    } ordered_word_t;

    // Mirror of the frame store; emits the back-to-front order on the closing word
    class depth_order_board;
        logic signed [DIR_W-1:0]   dir_x;
        logic signed [DIR_W-1:0]   dir_y;
        logic signed [DIR_W-1:0]   dir_z;
        logic signed [DEPTH_W-1:0] depth_mem[$];
        logic [TAG_W-1:0]          tag_mem[$];
        bit                        ovf_seen;
        ordered_word_t             due_q[$];
        int                        errors;

        function new();
            dir_x    = DIR_X_RESET;
            dir_y    = DIR_Y_RESET;
            dir_z    = DIR_Z_RESET;
            ovf_seen = 1'b0;
            errors   = 0;
        endfunction

        function void set_dir(logic [1:0] idx, logic [DIR_W-1:0] value);
            case (idx)
                REG_DIR_X: dir_x = value;
                REG_DIR_Y: dir_y = value;
                REG_DIR_Z: dir_z = value;
                default: ;
            endcase
        endfunction

        function void note_item(scene_item_t it);
            longint        sum;
            int            n;
            int            best;
            bit            taken[MAX_ITEMS];
            ordered_word_t w;
            // Store the depth, or flag the overflow once the store is full
            if (it.geo) begin
                if (depth_mem.size() < MAX_ITEMS) begin
                    sum = longint'(it.cx) * longint'(dir_x) + longint'(it.cy) * longint'(dir_y)
                        + longint'(it.cz) * longint'(dir_z);
                    depth_mem.push_back(sum[DEPTH_W-1:0]);
                    tag_mem.push_back(it.tag);
                end
                else begin
                    ovf_seen = 1'b1;
                end
            end
            if (!it.is_last)
                return;
            n = depth_mem.size();
            if (n == 0) begin
                w.tag     = '0;
                w.depth   = '0;
                w.is_last = 1'b1;
                w.none    = 1'b1;
                w.ovf     = ovf_seen;
                due_q.push_back(w);
            end
            // Pick the deepest remaining entry; the later-loaded one wins a tie
            for (int k = 0; k < n; k++) begin
                best = -1;
                for (int j = 0; j < n; j++)
                    if (!taken[j] && (best < 0 || depth_mem[j] >= depth_mem[best]))
                        best = j;
                taken[best] = 1'b1;
                w.tag     = tag_mem[best];
                w.depth   = depth_mem[best];
                w.is_last = (k == n - 1);
                w.none    = 1'b0;
                w.ovf     = ovf_seen;
                due_q.push_back(w);
            end
            depth_mem.delete();
            tag_mem.delete();
            ovf_seen = 1'b0;
        endfunction

        function void check(ordered_word_t got);
            ordered_word_t want;
            if (due_q.size() == 0) begin
                $error("result word with nothing due: out_tag %0h", got.tag);
                errors++;
                return;
            end
            want = due_q.pop_front();
            if (got.tag !== want.tag) begin
                $error("out_tag: expected %0h, actual %0h", want.tag, got.tag);
                errors++;
            end
            if (got.depth !== want.depth) begin
                $error("out_depth: expected %0d, actual %0d", want.depth, got.depth);
                errors++;
            end
            if (got.is_last !== want.is_last) begin
                $error("last_out: expected %0b, actual %0b", want.is_last, got.is_last);
                errors++;
            end
            if (got.none !== want.none) begin
                $error("none_rendered: expected %0b, actual %0b", want.none, got.none);
                errors++;
            end
            if (got.ovf !== want.ovf) begin
                $error("overflowed: expected %0b, actual %0b", want.ovf, got.ovf);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    vds_in_if  items_if ();
    vds_out_if results_if ();

    depth_order_board sb = new();

    int          tx_gap_pct   = 0;
    int          rx_stall_pct = 0;
    bit          hold_req     = 1'b0;
    bit          hold_done    = 1'b0;
    int          items_sent   = 0;
    scene_item_t prev_item;

    view_depth_sort #(
        .MAX_ITEMS (MAX_ITEMS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .results (results_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 clk = ~clk;

    function automatic scene_item_t mk(logic [TAG_W-1:0] tag, logic [CEN_W-1:0] cx,
                                       logic [CEN_W-1:0] cy, logic [CEN_W-1:0] cz,
                                       logic geo, logic is_last);
        scene_item_t it;
        it.tag     = tag;
        it.cx      = cx;
        it.cy      = cy;
        it.cz      = cz;
        it.geo     = geo;
        it.is_last = is_last;
        return it;
    endfunction

    // Mix of full-range, near-origin and extreme coordinates
    function automatic logic [CEN_W-1:0] rand_coord();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return $urandom;
        else if (r < 85)
            return 32'($urandom_range(1048576) - 524288);
        else if (r < 90)
            return 32'h8000_0000;
        else if (r < 95)
            return 32'h7FFF_FFFF;
        else
            return (r < 98) ? 32'h0 : 32'hFFFF_FFFF;
    endfunction

    function automatic scene_item_t make_item(int geo_pct, bit is_last);
        scene_item_t it;
        // Reuse the previous centre now and then to force equal depths
        if ($urandom_range(99) < 15) begin
            it = prev_item;
        end
        else begin
            it.cx = rand_coord();
            it.cy = rand_coord();
            it.cz = rand_coord();
        end
        it.tag     = 16'($urandom);
        it.geo     = ($urandom_range(99) < geo_pct);
        it.is_last = is_last;
        prev_item  = it;
        return it;
    endfunction

    task automatic send_item(input scene_item_t it);
        // Idle the sender at random before offering the word
        while ($urandom_range(99) < tx_gap_pct) begin
            items_if.valid <= 1'b0;
            @(posedge clk);
        end
        items_if.valid        <= 1'b1;
        items_if.item_tag     <= it.tag;
        items_if.center_x     <= it.cx;
        items_if.center_y     <= it.cy;
        items_if.center_z     <= it.cz;
        items_if.has_geometry <= it.geo;
        items_if.last_in      <= it.is_last;
        @(posedge clk);
        while (items_if.ready !== 1'b1)
            @(posedge clk);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic send_frame(input int n, input int geo_pct);
        for (int i = 0; i < n; i++)
            send_item(make_item(geo_pct, i == n - 1));
    endtask

    task automatic write_dir(input logic [1:0] idx, input logic [DIR_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        sb.set_dir(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid and hold until every due result has been taken
    task automatic drain(input int settle);
        items_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.due_q.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Result side: check accepted words, stall at random, hold off once on request
    initial
    begin
        int            hold_left;
        ordered_word_t got;
        hold_left = 0;
        results_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (results_if.valid === 1'b1 && results_if.ready === 1'b1) begin
                got.tag     = results_if.out_tag;
                got.depth   = results_if.out_depth;
                got.is_last = results_if.last_out;
                got.none    = results_if.none_rendered;
                got.ovf     = results_if.overflowed;
                sb.check(got);
            end
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                results_if.ready <= 1'b0;
            end
            else begin
                results_if.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial
    begin
        int start;
        int r;
        // Known centre for the first reuse
        prev_item = mk(16'h0000, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        rst_n                 <= 1'b0;
        items_if.valid        <= 1'b0;
        items_if.item_tag     <= '0;
        items_if.center_x     <= '0;
        items_if.center_y     <= '0;
        items_if.center_z     <= '0;
        items_if.has_geometry <= 1'b0;
        items_if.last_in      <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset direction: single item, empty frame, longer frame with ties and a dropped word
        send_item(mk(16'h0001, 32'h0, 32'h0, 32'h0001_0000, 1'b1, 1'b1));
        send_item(mk(16'h0002, 32'h5, 32'h5, 32'h5, 1'b0, 1'b1));
        send_item(mk(16'h0010, 32'h0, 32'h0, 32'd100, 1'b1, 1'b0));
        send_item(mk(16'h0011, 32'h0, 32'h0, 32'd100, 1'b1, 1'b0));
        send_item(mk(16'h0012, 32'h0, 32'h0, -32'sd5, 1'b0, 1'b0));
        send_item(mk(16'h0013, 32'h0, 32'h0, 32'd300, 1'b1, 1'b0));
        send_item(mk(16'h0014, 32'h0, 32'h0, 32'd100, 1'b1, 1'b1));
        drain(20);

        // Extreme directions against extreme centres
        write_dir(REG_DIR_X, 16'h8000);
        write_dir(REG_DIR_Y, 16'h7FFF);
        write_dir(REG_DIR_Z, 16'h8000);
        send_item(mk(16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0));
        send_item(mk(16'h0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0));
        send_item(mk(16'hAAAA, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0));
        send_item(mk(16'h5555, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
        drain(20);

        write_dir(REG_DIR_X, 16'h7FFF);
        write_dir(REG_DIR_Y, 16'h8000);
        write_dir(REG_DIR_Z, 16'h7FFF);
        send_item(mk(16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0));
        send_item(mk(16'h0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0));
        send_item(mk(16'h1234, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0));
        send_item(mk(16'h4321, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0));
        send_item(mk(16'h5A5A, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1));

        // Random frames under each idling mix
        for (int pass = 0; pass < 4; pass++) begin
            drain(20);
            case (pass)
                0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_gap_pct = 45; rx_stall_pct = 0;  end
                2: begin tx_gap_pct = 0;  rx_stall_pct = 45; end
                default: begin tx_gap_pct = 9; rx_stall_pct = 9; end
            endcase
            if (pass == 2) begin
                // Zero direction: every depth ties
                write_dir(REG_DIR_X, 16'h0000);
                write_dir(REG_DIR_Y, 16'h0000);
                write_dir(REG_DIR_Z, 16'h0000);
            end
            else begin
                write_dir(REG_DIR_X, 16'($urandom));
                write_dir(REG_DIR_Y, 16'($urandom));
                write_dir(REG_DIR_Z, 16'($urandom));
            end
            if (pass == 0)
                hold_req = 1'b1;
            if (pass == 0 || pass == 3)
                send_frame(MAX_ITEMS + $urandom_range(1, 6), 100);
            start = items_sent;
            while (items_sent - start < ITEMS_PER_PASS) begin
                r = $urandom_range(99);
                if (r < 5)
                    send_frame($urandom_range(1, 3), 0);
                else if (r < 85)
                    send_frame($urandom_range(1, 8), 85);
                else
                    send_frame($urandom_range(9, 30), 85);
            end
        end

        drain(100);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
